FILE: rtl/hciu_pkg.sv
// ----------------------------------------------------------------------------
// hciu_pkg
// Types and constants shared by the HCI UART receive deframer.
// ----------------------------------------------------------------------------
package hciu_pkg;

  localparam int unsigned OffW   = 17;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [7:0]  AclHdrLen  = 8'd5;
  localparam logic [7:0]  EvtHdrLen  = 8'd3;
  localparam logic [15:0] OpcodeNone = 16'hFFFF;
  localparam logic [7:0]  StatusNone = 8'hFF;

  typedef enum logic [1:0] {
    KIND_RX       = 2'd0,
    KIND_ACL_SENT = 2'd1,
    KIND_CMD_SENT = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_PENDING  = 3'd0,
    CFG_ACL_TYPE     = 3'd1,
    CFG_EVT_TYPE     = 3'd2,
    CFG_CMD_COMPLETE = 3'd3,
    CFG_NUM_COMPLETED = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            packet_is_event;
    logic [OffW-1:0] byte_offset;
    logic            last_of_packet;
    logic [7:0]      pending_count;
    logic            credit_available;
    logic [15:0]     cmd_opcode;
    logic [7:0]      cmd_status;
  } out_t;

  typedef struct packed {
    logic [7:0] acl_type;
    logic [7:0] evt_type;
    logic [7:0] cmd_complete;
    logic [7:0] num_completed;
  } front_cfg_t;

  // Classified transfer handed from the framer to the accounting stage.
  typedef struct packed {
    logic [7:0]      data_byte;
    logic            is_event;
    logic [OffW-1:0] offset;
    logic            last;
    logic            inc_pending;
    logic            clr_latch;
    logic            dec_pending;
    logic [15:0]     dec_count;
    logic            set_latch;
    logic [15:0]     opcode;
    logic [7:0]      status;
  } op_t;

endpackage

FILE: rtl/hciu_front.sv
// ----------------------------------------------------------------------------
// hciu_front
// H4 framer: tracks packet offsets and lengths and classifies each transfer.
// ----------------------------------------------------------------------------
module hciu_front import hciu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  front_cfg_t cfg_i,
  input  logic       accept_i,
  input  in_t        in_i,
  output logic       emit_o,
  output op_t        op_o
);

  logic [OffW-1:0] count_q, count_d;
  logic            kind_q, kind_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [OffW-1:0] total_q, total_d;
  logic [7:0]      evt_code_q, evt_code_d;
  logic [7:0]      handle_q, handle_d;
  logic [7:0]      pair_lo_q, pair_lo_d;
  logic [15:0]     stg_op_q, stg_op_d;
  logic [7:0]      stg_st_q, stg_st_d;

  logic [OffW-1:0] off;
  logic [OffW-1:0] rel;
  logic [OffW:0]   off_p1;
  logic [7:0]      b;
  logic            last;

  assign off    = count_q;
  assign b      = in_i.rx_byte;
  assign rel    = off - OffW'(4);
  assign off_p1 = {1'b0, off} + (OffW+1)'(1);

  always_comb begin
    count_d    = count_q;
    kind_d     = kind_q;
    len_lo_d   = len_lo_q;
    total_d    = total_q;
    evt_code_d = evt_code_q;
    handle_d   = handle_q;
    pair_lo_d  = pair_lo_q;
    stg_op_d   = stg_op_q;
    stg_st_d   = stg_st_q;
    last       = 1'b0;
    emit_o     = 1'b0;
    op_o       = '0;
    op_o.data_byte = b;

    case (in_i.kind)
      KIND_ACL_SENT: begin
        emit_o           = 1'b1;
        op_o.data_byte   = '0;
        op_o.inc_pending = 1'b1;
      end
      KIND_CMD_SENT: begin
        emit_o         = 1'b1;
        op_o.data_byte = '0;
        op_o.clr_latch = 1'b1;
      end
      KIND_RX: begin
        if (off == '0) begin
          if (b == cfg_i.acl_type || b == cfg_i.evt_type) begin
            kind_d        = (b != cfg_i.acl_type);
            total_d       = '0;
            count_d       = OffW'(1);
            emit_o        = 1'b1;
            op_o.is_event = (b != cfg_i.acl_type);
          end
        end else begin
          emit_o = 1'b1;
          if (!kind_q) begin
            if (off == OffW'(3)) begin
              len_lo_d = b;
            end else if (off == OffW'(4)) begin
              total_d = OffW'(AclHdrLen) + OffW'({b, len_lo_q});
            end
            last = (off >= OffW'(4)) && (off_p1 >= {1'b0, total_d});
          end else begin
            if (off == OffW'(1)) begin
              evt_code_d = b;
            end else if (off == OffW'(2)) begin
              len_lo_d = b;
              total_d  = OffW'(EvtHdrLen) + OffW'(b);
            end else if (off == OffW'(3)) begin
              handle_d = b;
            end
            if (off == OffW'(4)) begin
              stg_op_d[7:0] = b;
            end else if (off == OffW'(5)) begin
              stg_op_d[15:8] = b;
            end else if (off == OffW'(6)) begin
              stg_st_d = b;
            end
            if (evt_code_d == cfg_i.num_completed && off >= OffW'(4)) begin
              if (rel[1:0] == 2'd2) begin
                pair_lo_d = b;
              end else if (rel[1:0] == 2'd3 &&
                           rel[OffW-1:2] < (OffW-2)'(handle_d)) begin
                op_o.dec_pending = 1'b1;
                op_o.dec_count   = {b, pair_lo_q};
              end
            end
            last = (off >= OffW'(2)) && (off_p1 >= {1'b0, total_d});
            if (last && evt_code_d == cfg_i.cmd_complete && len_lo_d >= 8'd4) begin
              op_o.set_latch = 1'b1;
              op_o.opcode    = stg_op_d;
              op_o.status    = stg_st_d;
            end
          end
          count_d       = last ? '0 : off_p1[OffW-1:0];
          op_o.is_event = kind_q;
          op_o.offset   = off;
          op_o.last     = last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      kind_q     <= 1'b0;
      len_lo_q   <= '0;
      total_q    <= '0;
      evt_code_q <= '0;
      handle_q   <= '0;
      pair_lo_q  <= '0;
      stg_op_q   <= '0;
      stg_st_q   <= '0;
    end else if (accept_i) begin
      count_q    <= count_d;
      kind_q     <= kind_d;
      len_lo_q   <= len_lo_d;
      total_q    <= total_d;
      evt_code_q <= evt_code_d;
      handle_q   <= handle_d;
      pair_lo_q  <= pair_lo_d;
      stg_op_q   <= stg_op_d;
      stg_st_q   <= stg_st_d;
    end
  end

endmodule

FILE: rtl/hciu_fifo.sv
// ----------------------------------------------------------------------------
// hciu_fifo
// Small register queue of classified transfers between framer and back end.
// ----------------------------------------------------------------------------
module hciu_fifo import hciu_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  op_t  wdata_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output op_t  rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/hciu_back.sv
// ----------------------------------------------------------------------------
// hciu_back
// Credit and Command Complete bookkeeping; holds the result register.
// ----------------------------------------------------------------------------
module hciu_back import hciu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] max_pending_i,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_take_o,
  output logic       empty_o,
  input  logic       pop_i,
  output out_t       out_o
);

  logic [7:0]  pend_q, pend_d;
  logic [15:0] lat_op_q, lat_op_d;
  logic [7:0]  lat_st_q, lat_st_d;
  logic        out_vld_q;
  out_t        out_q, out_d;

  assign empty_o   = !out_vld_q;
  assign op_take_o = op_valid_i && (!out_vld_q || pop_i);
  assign out_o     = out_q;

  always_comb begin
    pend_d   = pend_q;
    lat_op_d = lat_op_q;
    lat_st_d = lat_st_q;
    if (op_i.inc_pending && pend_q != 8'hFF) begin
      pend_d = pend_q + 8'd1;
    end
    if (op_i.dec_pending) begin
      if (op_i.dec_count != '0 && {8'd0, pend_q} > op_i.dec_count) begin
        pend_d = pend_q - op_i.dec_count[7:0];
      end else begin
        pend_d = '0;
      end
    end
    if (op_i.clr_latch) begin
      lat_op_d = OpcodeNone;
      lat_st_d = StatusNone;
    end
    if (op_i.set_latch) begin
      lat_op_d = op_i.opcode;
      lat_st_d = op_i.status;
    end
    out_d.data_byte        = op_i.data_byte;
    out_d.packet_is_event  = op_i.is_event;
    out_d.byte_offset      = op_i.offset;
    out_d.last_of_packet   = op_i.last;
    out_d.pending_count    = pend_d;
    out_d.credit_available = (pend_d < max_pending_i);
    out_d.cmd_opcode       = lat_op_d;
    out_d.cmd_status       = lat_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      lat_op_q  <= OpcodeNone;
      lat_st_q  <= StatusNone;
      out_vld_q <= 1'b0;
    end else begin
      if (op_take_o) begin
        pend_q    <= pend_d;
        lat_op_q  <= lat_op_d;
        lat_st_q  <= lat_st_d;
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_take_o) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: rtl/hci_uart_rx_deframer_credits.sv
// ----------------------------------------------------------------------------
// hci_uart_rx_deframer_credits
// H4 receive deframer with ACL credit accounting and Command Complete latch.
// ----------------------------------------------------------------------------
//  channel   | signals                          | transfer when
//  ----------+----------------------------------+------------------------------
//  input     | push, full, in_data_i            | push && !full
//  result    | empty, pop, out_data_o           | pop && !empty
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i | cfg_we_i
//
// One item per cycle sustained while full stays low. An input transfer
// writes its entry into the queue; the entry moves into the result register
// once that register is empty or being popped, and the result can then
// transfer. full rises once the queue holds QueueDepth items while the
// result register is not popped. Reset loads the register defaults and
// empties the queue and the result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hci_uart_rx_deframer_credits import hciu_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_t                in_data_i,
  output logic               empty,
  input  logic               pop,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  logic [7:0] max_pend_q;
  front_cfg_t fcfg_q;

  logic accept, emit, q_empty, q_take;
  op_t  f_op, q_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pend_q           <= 8'd1;
      fcfg_q.acl_type      <= 8'd2;
      fcfg_q.evt_type      <= 8'd4;
      fcfg_q.cmd_complete  <= 8'd14;
      fcfg_q.num_completed <= 8'd19;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_PENDING:   max_pend_q           <= cfg_wdata_i;
        CFG_ACL_TYPE:      fcfg_q.acl_type      <= cfg_wdata_i;
        CFG_EVT_TYPE:      fcfg_q.evt_type      <= cfg_wdata_i;
        CFG_CMD_COMPLETE:  fcfg_q.cmd_complete  <= cfg_wdata_i;
        CFG_NUM_COMPLETED: fcfg_q.num_completed <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  hciu_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i    (fcfg_q),
    .accept_i (accept),
    .in_i     (in_data_i),
    .emit_o   (emit),
    .op_o     (f_op)
  );

  hciu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i    (accept && emit),
    .wdata_i (f_op),
    .full_o  (full),
    .rd_i    (q_take),
    .empty_o (q_empty),
    .rdata_o (q_op)
  );

  hciu_back u_back (
    .clk_i,
    .rst_ni,
    .max_pending_i (max_pend_q),
    .op_valid_i    (!q_empty),
    .op_i          (q_op),
    .op_take_o     (q_take),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_o         (out_data_o)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives H4 byte streams and send items into hci_uart_rx_deframer_credits.
// A untimed model of the framer, credit counter and opcode latch predicts
// every tagged byte not typed by its directed entry. A short directed list
// runs first, then random packet streams under several register settings,
// with random push and pop gaps and one long pop hold-off backing up input.
// ----------------------------------------------------------------------------
module testbench;
  import hciu_pkg::*;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t res;
  } vec_t;

  localparam out_t NoTag = '0;
  localparam int unsigned DirLen = 27;
  localparam vec_t DirTab [DirLen] = '{
    {KIND_UNUSED,   8'hFF, 1'b0, NoTag},
    {KIND_RX,       8'h00, 1'b0, NoTag},
    {KIND_ACL_SENT, 8'h00, 1'b1, 8'h00, 1'b0, 17'd0, 1'b0, 8'd1, 1'b0, OpcodeNone, StatusNone},
    {KIND_RX,       8'h04, 1'b0, NoTag},
    {KIND_RX,       8'h0E, 1'b0, NoTag},
    {KIND_RX,       8'h04, 1'b0, NoTag},
    {KIND_RX,       8'h01, 1'b0, NoTag},
    {KIND_RX,       8'h34, 1'b0, NoTag},
    {KIND_RX,       8'h12, 1'b0, NoTag},
    {KIND_RX,       8'h00, 1'b1, 8'h00, 1'b1, 17'd6, 1'b1, 8'd1, 1'b0, 16'h1234, 8'h00},
    {KIND_RX,       8'h04, 1'b0, NoTag},
    {KIND_RX,       8'h13, 1'b0, NoTag},
    {KIND_RX,       8'h05, 1'b0, NoTag},
    {KIND_RX,       8'h01, 1'b0, NoTag},
    {KIND_RX,       8'h01, 1'b0, NoTag},
    {KIND_RX,       8'h00, 1'b0, NoTag},
    {KIND_RX,       8'h01, 1'b0, NoTag},
    {KIND_RX,       8'h00, 1'b1, 8'h00, 1'b1, 17'd7, 1'b1, 8'd0, 1'b1, 16'h1234, 8'h00},
    {KIND_CMD_SENT, 8'h00, 1'b1, 8'h00, 1'b0, 17'd0, 1'b0, 8'd0, 1'b1, OpcodeNone, StatusNone},
    {KIND_RX,       8'h02, 1'b0, NoTag},
    {KIND_RX,       8'hFF, 1'b0, NoTag},
    {KIND_RX,       8'hFF, 1'b0, NoTag},
    {KIND_RX,       8'h00, 1'b0, NoTag},
    {KIND_RX,       8'h00, 1'b1, 8'h00, 1'b0, 17'd4, 1'b1, 8'd0, 1'b1, OpcodeNone, StatusNone},
    {KIND_RX,       8'h04, 1'b0, NoTag},
    {KIND_RX,       8'hFF, 1'b0, NoTag},
    {KIND_RX,       8'h00, 1'b1, 8'h00, 1'b1, 17'd2, 1'b1, 8'd0, 1'b1, OpcodeNone, StatusNone}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  in_t                in_data_i;
  logic               empty;
  logic               pop;
  out_t               out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [7:0]         cfg_wdata_i;

  hci_uart_rx_deframer_credits uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // register copies
  logic [7:0]  cfg_max  = 8'd1;
  logic [7:0]  cfg_acl  = 8'd2;
  logic [7:0]  cfg_evt  = 8'd4;
  logic [7:0]  cfg_cc   = 8'd14;
  logic [7:0]  cfg_nocp = 8'd19;

  // framer and accounting state
  logic [16:0] offs_q    = '0;
  logic        pkt_evt   = 1'b0;
  logic [7:0]  len_lo    = '0;
  logic [16:0] pkt_len   = '0;
  logic [7:0]  evt_code  = '0;
  logic [7:0]  n_handles = '0;
  logic [7:0]  cnt_lo    = '0;
  logic [15:0] stage_op  = '0;
  logic [7:0]  stage_st  = '0;
  logic [7:0]  acl_out   = '0;
  logic [15:0] op_latch  = OpcodeNone;
  logic [7:0]  st_latch  = StatusNone;

  out_t        tagged_q [$];
  out_t        mon_want;
  int unsigned n_tagged = 0;
  int unsigned n_bad = 0;
  bit          gaps_on = 1'b1;
  bit          hold_go = 1'b0;

  function automatic bit tag_byte(input in_t it, output out_t res);
    logic [7:0]  b;
    logic [16:0] off;
    logic [16:0] rel;
    logic [15:0] n;
    logic        done;
    b = it.rx_byte;
    off = offs_q;
    done = 1'b0;
    res = '0;
    if (it.kind == KIND_UNUSED) return 1'b0;
    if (it.kind == KIND_ACL_SENT) begin
      if (acl_out != 8'hFF) acl_out++;
    end else if (it.kind == KIND_CMD_SENT) begin
      op_latch = OpcodeNone;
      st_latch = StatusNone;
    end else if (off == '0) begin
      if (b == cfg_acl) pkt_evt = 1'b0;
      else if (b == cfg_evt) pkt_evt = 1'b1;
      else return 1'b0;
      pkt_len = '0;
      offs_q = 17'd1;
      res.data_byte = b;
      res.packet_is_event = pkt_evt;
    end else begin
      if (!pkt_evt) begin
        if (off == 3) len_lo = b;
        else if (off == 4) pkt_len = AclHdrLen + {b, len_lo};
        done = (off >= 4) && (off + 1 >= pkt_len);
      end else begin
        if (off == 1) begin
          evt_code = b;
        end else if (off == 2) begin
          len_lo = b;
          pkt_len = EvtHdrLen + b;
        end else if (off == 3) begin
          n_handles = b;
        end
        if (off == 4) stage_op[7:0] = b;
        else if (off == 5) stage_op[15:8] = b;
        else if (off == 6) stage_st = b;
        if (evt_code == cfg_nocp && off >= 4) begin
          rel = off - 17'd4;
          if (rel[1:0] == 2'd2) begin
            cnt_lo = b;
          end else if (rel[1:0] == 2'd3 && (rel >> 2) < n_handles) begin
            n = {b, cnt_lo};
            if (n != 0 && acl_out > n) acl_out = acl_out - n[7:0];
            else acl_out = '0;
          end
        end
        if (off >= 2 && off + 1 >= pkt_len) begin
          done = 1'b1;
          if (evt_code == cfg_cc && len_lo >= 4) begin
            op_latch = stage_op;
            st_latch = stage_st;
          end
        end
      end
      offs_q = done ? '0 : off + 17'd1;
      res.data_byte = b;
      res.packet_is_event = pkt_evt;
      res.byte_offset = off;
      res.last_of_packet = done;
    end
    res.pending_count = acl_out;
    res.credit_available = acl_out < cfg_max;
    res.cmd_opcode = op_latch;
    res.cmd_status = st_latch;
    return 1'b1;
  endfunction

  // starts and ends at a falling edge
  task automatic send_item(input in_t it, input bit typed = 1'b0, input out_t typed_res = '0);
    out_t res;
    bit   got;
    while (gaps_on && $urandom_range(0, 99) < 29) @(negedge clk_i);
    push = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (full);
    got = tag_byte(it, res);
    if (got) begin
      tagged_q.push_back(typed ? typed_res : res);
      n_tagged++;
    end
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < 3) send_item('{kind_e'($urandom_range(1, 3)), 8'($urandom)});
    send_item('{KIND_RX, b});
  endtask

  // zero fill runs until the open packet, if any, closes
  task automatic realign();
    while (offs_q != '0) send_byte(8'h00);
  endtask

  task automatic gen_packet();
    logic [7:0]  pkt [$];
    int unsigned r, len, np, cut, i;
    logic [15:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 40 || cfg_acl == cfg_evt) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300) : $urandom_range(0, 16);
      pkt = '{cfg_acl, 8'($urandom), 8'($urandom), len[7:0], len[15:8]};
      repeat (len) pkt.push_back(8'($urandom));
    end else if (r < 60) begin
      len = $urandom_range(0, 8);
      pkt = '{cfg_evt, cfg_cc, len[7:0]};
      repeat (len) pkt.push_back(8'($urandom));
    end else if (r < 80) begin
      np = $urandom_range(0, 4);
      pkt = '{cfg_evt, cfg_nocp, 8'h00, np[7:0]};
      r = $urandom_range(0, 99);
      if (r < 15) np++;
      else if (r < 30 && np != 0) np--;
      pkt[2] = 8'(1 + 4 * np);
      repeat (np) begin
        r = $urandom_range(0, 99);
        if (r < 60) cnt = 16'($urandom_range(0, 3));
        else if (r < 75) cnt = '0;
        else cnt = 16'($urandom);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom_range(0, 15)));
        pkt.push_back(cnt[7:0]);
        pkt.push_back(cnt[15:8]);
      end
    end else begin
      len = $urandom_range(0, 12);
      pkt = '{cfg_evt, 8'($urandom), len[7:0]};
      repeat (len) pkt.push_back(8'($urandom));
    end
    cut = pkt.size();
    if (cut > 1 && $urandom_range(0, 99) < 6) cut = $urandom_range(1, cut - 1);
    for (i = 0; i < cut; i++) send_byte(pkt[i]);
    realign();
  endtask

  task automatic gen_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_item('{KIND_ACL_SENT, 8'($urandom)});
    end else if (r < 14) begin
      send_item('{KIND_CMD_SENT, 8'($urandom)});
    end else if (r < 16) begin
      send_item('{KIND_UNUSED, 8'($urandom)});
    end else if (r < 20) begin
      send_byte(8'($urandom));
      realign();
    end else begin
      gen_packet();
    end
  endtask

  task automatic drain();
    while (tagged_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_MAX_PENDING:   cfg_max = val;
      CFG_ACL_TYPE:      cfg_acl = val;
      CFG_EVT_TYPE:      cfg_evt = val;
      CFG_CMD_COMPLETE:  cfg_cc = val;
      CFG_NUM_COMPLETED: cfg_nocp = val;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_bad++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #16_000_000;
    $display("hci_uart_rx_deframer_credits: mismatch");
    $finish;
  end

  initial begin : pop_side
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = !(gaps_on && $urandom_range(0, 99) < 29);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (tagged_q.size() == 0) begin
        n_bad++;
        $display("%0t ns: expected none, got %h", $time, out_data_o);
      end else begin
        mon_want = tagged_q.pop_front();
        check_field("data_byte", mon_want.data_byte, out_data_o.data_byte);
        check_field("packet_is_event", mon_want.packet_is_event, out_data_o.packet_is_event);
        check_field("byte_offset", mon_want.byte_offset, out_data_o.byte_offset);
        check_field("last_of_packet", mon_want.last_of_packet, out_data_o.last_of_packet);
        check_field("pending_count", mon_want.pending_count, out_data_o.pending_count);
        check_field("credit_available", mon_want.credit_available,
                    out_data_o.credit_available);
        check_field("cmd_opcode", mon_want.cmd_opcode, out_data_o.cmd_opcode);
        check_field("cmd_status", mon_want.cmd_status, out_data_o.cmd_status);
      end
    end
  end

  initial begin : stim
    logic [7:0]  vals [5];
    int unsigned base, ph, k;
    rst_ni = 1'b0;
    push = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MAX_PENDING;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirTab[k]) send_item(DirTab[k].item, DirTab[k].typed, DirTab[k].res);

    for (ph = 0; ph < 8; ph++) begin
      if (ph != 0) begin
        drain();
        case (ph)
          1: vals = '{8'd255, 8'h00, 8'hFF, 8'h00, 8'hFF};
          2: vals = '{8'd0, 8'hFF, 8'h00, 8'hFF, 8'h00};
          3: vals = '{8'd3, 8'h07, 8'h07, 8'h0E, 8'h13};
          4: vals = '{8'($urandom_range(1, 8)), 8'h02, 8'h04, 8'h0E, 8'h0E};
          default: foreach (vals[k]) vals[k] = 8'($urandom);
        endcase
        for (k = 0; k < 5; k++) write_reg(cfg_idx_e'(k), vals[k]);
      end
      gaps_on = (ph != 3);
      if (ph == 1) begin
        hold_go = 1'b1;
        repeat (260) send_item('{KIND_ACL_SENT, 8'($urandom)});
      end
      base = n_tagged;
      while (n_tagged - base < 125) gen_step();
    end

    while (tagged_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("hci_uart_rx_deframer_credits: match");
    end else begin
      $display("hci_uart_rx_deframer_credits: mismatch");
    end
    $finish;
  end

endmodule
